// ===== src/hrp_pkg.sv =====
package hrp_pkg;

  typedef enum logic [2:0] {
    PH_METHOD,
    PH_SKIP,
    PH_PATH,
    PH_REST,
    PH_HEADER,
    PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    KIND_UNKNOWN,
    KIND_GET,
    KIND_POST
  } kind_t;

  typedef enum logic [2:0] {
    V_OK,
    V_BAD_REQUEST,
    V_NOT_ALLOWED,
    V_URI_TOO_LONG,
    V_TOO_LARGE,
    V_ABORT
  } verdict_t;

  typedef enum logic [2:0] {
    CT_HTML,
    CT_JPEG,
    CT_PNG,
    CT_GIF,
    CT_ICON,
    CT_UNKNOWN
  } ctype_t;

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_DOT   = 8'h2E;

  localparam logic [31:0] TOK_GET  = 32'h0047_4554;
  localparam logic [31:0] TOK_POST = 32'h504F_5354;

  localparam logic [39:0] EXT_HTM  = 40'h00_2E68_746D;
  localparam logic [39:0] EXT_HTML = 40'h2E_6874_6D6C;
  localparam logic [39:0] EXT_JPG  = 40'h00_2E6A_7067;
  localparam logic [39:0] EXT_JPEG = 40'h2E_6A70_6567;
  localparam logic [39:0] EXT_PNG  = 40'h00_2E70_6E67;
  localparam logic [39:0] EXT_GIF  = 40'h00_2E67_6966;
  localparam logic [39:0] EXT_ICO  = 40'h00_2E69_636F;

  localparam int DEFAULT_NAME_LEN = 10;
  localparam logic [15:0] LINE_LIMIT_RESET = 16'd5840;

  localparam int JOBQ_DEPTH = 2;
  localparam int OUTQ_DEPTH = 3;
  localparam int OQ_PW      = $clog2(OUTQ_DEPTH);
  localparam int OQ_CW      = $clog2(OUTQ_DEPTH + 1);

  typedef struct packed {
    logic     is_name;
    verdict_t verdict;
    ctype_t   ctype;
    logic     use_default;
    logic     bank;
  } job_t;

  typedef struct packed {
    logic       en;
    logic       bank;
    logic [7:0] data;
  } name_wr_t;

  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

  typedef struct packed {
    verdict_t   verdict;
    ctype_t     ctype;
    logic [7:0] name_char;
    logic       char_valid;
    logic       last;
  } result_t;

  function automatic ctype_t classify(input logic dot_seen, input logic [2:0] ext_len,
                                      input logic [39:0] tok);
    ctype_t ct;
    ct = CT_UNKNOWN;
    if (dot_seen && ext_len == 3'd4) begin
      if (tok == EXT_HTM) ct = CT_HTML;
      else if (tok == EXT_JPG) ct = CT_JPEG;
      else if (tok == EXT_PNG) ct = CT_PNG;
      else if (tok == EXT_GIF) ct = CT_GIF;
      else if (tok == EXT_ICO) ct = CT_ICON;
    end else if (dot_seen && ext_len == 3'd5) begin
      if (tok == EXT_HTML) ct = CT_HTML;
      else if (tok == EXT_JPEG) ct = CT_JPEG;
    end
    return ct;
  endfunction

  function automatic logic [7:0] default_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h69;
      4'd1:    c = 8'h6E;
      4'd2:    c = 8'h64;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h78;
      4'd5:    c = 8'h2E;
      4'd6:    c = 8'h68;
      4'd7:    c = 8'h74;
      4'd8:    c = 8'h6D;
      4'd9:    c = 8'h6C;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== src/hrp_front.sv =====
module hrp_front
  import hrp_pkg::*;
#(
  parameter int NAME_BYTES = 30,
  localparam int LEN_W = $clog2(NAME_BYTES)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  input  logic [15:0]      cfg_data,
  input  logic             push,
  input  logic [7:0]       data_byte,
  input  logic             stream_end,
  output logic             full,
  input  logic             jq_full,
  output logic             job_push,
  output job_t             job,
  output logic [LEN_W-1:0] job_len,
  output name_wr_t         wr,
  output logic [LEN_W-1:0] wr_idx,
  input  bank_rel_t        bank_rel
);

  phase_t phase, phase_next;

  logic [15:0]      line_limit, line_limit_next;
  logic [31:0]      method_token, method_token_next;
  logic [2:0]       method_count, method_count_next;
  kind_t            method_kind, method_kind_next;
  logic [LEN_W-1:0] name_length, name_length_next;
  logic [15:0]      line_length, line_length_next;
  logic             colon, colon_next;
  logic             cut, cut_next;
  logic             too_long, too_long_next;
  logic             skip_next, skip_next_next;
  logic             dot_seen, dot_seen_next;
  logic [2:0]       ext_len, ext_len_next;
  logic [39:0]      ext_token, ext_token_next;
  logic             use_default, use_default_next;
  logic             bank, bank_next;
  logic [1:0]       busy, busy_next;

  logic        accept;
  logic [15:0] line_inc;

  // the path writes into the current name bank, which must be free of emission
  assign full   = (jq_full && phase != PH_DONE) || (phase == PH_PATH && busy[bank]);
  assign accept = push && !full;
  assign line_inc = (line_length != 16'hFFFF) ? line_length + 16'd1 : line_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_METHOD;
    end else begin
      phase <= phase_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    line_limit_next   = line_limit;
    method_token_next = method_token;
    method_count_next = method_count;
    method_kind_next  = method_kind;
    name_length_next  = name_length;
    line_length_next  = line_length;
    colon_next        = colon;
    cut_next          = cut;
    too_long_next     = too_long;
    skip_next_next    = skip_next;
    dot_seen_next     = dot_seen;
    ext_len_next      = ext_len;
    ext_token_next    = ext_token;
    use_default_next  = use_default;
    bank_next         = bank;
    busy_next         = busy;

    job_push         = 1'b0;
    job.is_name      = 1'b0;
    job.verdict      = V_ABORT;
    job.ctype        = CT_HTML;
    job.use_default  = use_default;
    job.bank         = bank;
    job_len          = name_length;
    wr.en            = 1'b0;
    wr.bank          = bank;
    wr.data          = data_byte;
    wr_idx           = name_length;

    if (bank_rel.en) busy_next[bank_rel.bank] = 1'b0;
    if (cfg_valid) line_limit_next = cfg_data;

    if (accept) begin
      if (stream_end) begin
        case (phase)
          PH_METHOD, PH_SKIP, PH_PATH, PH_REST: begin
            job_push    = 1'b1;
            job.verdict = V_ABORT;
          end
          PH_HEADER: begin
            job_push    = 1'b1;
            job.verdict = V_TOO_LARGE;
          end
          default: ;
        endcase
        // rearm for the next request
        phase_next        = PH_METHOD;
        method_token_next = '0;
        method_count_next = '0;
        method_kind_next  = KIND_UNKNOWN;
        name_length_next  = '0;
        line_length_next  = '0;
        colon_next        = 1'b0;
        cut_next          = 1'b0;
        too_long_next     = 1'b0;
        skip_next_next    = 1'b0;
        dot_seen_next     = 1'b0;
        ext_len_next      = '0;
        ext_token_next    = '0;
        use_default_next  = 1'b0;
      end else if (phase != PH_DONE) begin
        if (skip_next) begin
          skip_next_next = 1'b0;
        end else if (data_byte == CH_CR) begin
          skip_next_next   = 1'b1;
          line_length_next = '0;
          case (phase)
            PH_REST: begin
              if (method_kind == KIND_UNKNOWN) begin
                job_push    = 1'b1;
                job.verdict = V_NOT_ALLOWED;
                phase_next  = PH_DONE;
              end else if (method_kind == KIND_GET && too_long) begin
                job_push    = 1'b1;
                job.verdict = V_URI_TOO_LONG;
                phase_next  = PH_DONE;
              end else begin
                colon_next    = 1'b0;
                cut_next      = 1'b0;
                too_long_next = 1'b0;
                phase_next    = PH_HEADER;
              end
            end
            PH_HEADER: begin
              if (line_length == 16'd0) begin
                job_push   = 1'b1;
                phase_next = PH_DONE;
                if (method_kind == KIND_GET) begin
                  job.is_name     = 1'b1;
                  job.verdict     = V_OK;
                  job.ctype       = classify(dot_seen, ext_len, ext_token);
                  bank_next       = ~bank;
                  busy_next[bank] = 1'b1;
                end else begin
                  job.verdict = V_NOT_ALLOWED;
                end
              end else if (!colon) begin
                job_push    = 1'b1;
                job.verdict = V_BAD_REQUEST;
                phase_next  = PH_DONE;
              end else begin
                colon_next = 1'b0;
              end
            end
            default: begin
              job_push    = 1'b1;
              job.verdict = V_ABORT;
              phase_next  = PH_DONE;
            end
          endcase
        end else begin
          line_length_next = line_inc;
          if (line_inc >= line_limit) begin
            job_push    = 1'b1;
            job.verdict = (phase == PH_HEADER) ? V_TOO_LARGE : V_ABORT;
            phase_next  = PH_DONE;
          end else begin
            case (phase)
              PH_METHOD: begin
                if (data_byte == CH_SPACE) begin
                  if (method_count == 3'd3 && method_token == TOK_GET) begin
                    method_kind_next = KIND_GET;
                    phase_next       = PH_SKIP;
                  end else if (method_count == 3'd4 && method_token == TOK_POST) begin
                    method_kind_next = KIND_POST;
                    phase_next       = PH_REST;
                  end else begin
                    method_kind_next = KIND_UNKNOWN;
                    phase_next       = PH_REST;
                  end
                end else begin
                  method_token_next = {method_token[23:0], data_byte};
                  if (method_count != 3'd6) method_count_next = method_count + 3'd1;
                end
              end
              PH_SKIP: begin
                phase_next = PH_PATH;
              end
              PH_PATH: begin
                if (data_byte == CH_SPACE) begin
                  if (name_length == '0 && !too_long) begin
                    use_default_next = 1'b1;
                    name_length_next = LEN_W'(DEFAULT_NAME_LEN);
                    dot_seen_next    = 1'b1;
                    ext_len_next     = 3'd5;
                    ext_token_next   = EXT_HTML;
                  end
                  phase_next = PH_REST;
                end else if (data_byte == CH_QMARK) begin
                  cut_next = 1'b1;
                end else if (!cut) begin
                  if (name_length < LEN_W'(NAME_BYTES - 1)) begin
                    wr.en            = 1'b1;
                    name_length_next = name_length + 1'b1;
                    // extension runs from the first dot to the end of the name
                    if (!dot_seen && data_byte == CH_DOT) begin
                      dot_seen_next  = 1'b1;
                      ext_len_next   = 3'd1;
                      ext_token_next = {32'd0, data_byte};
                    end else if (dot_seen) begin
                      if (ext_len != 3'd6) ext_len_next = ext_len + 3'd1;
                      ext_token_next = {ext_token[31:0], data_byte};
                    end
                  end else begin
                    too_long_next = 1'b1;
                  end
                end
              end
              PH_HEADER: begin
                if (data_byte == CH_COLON) colon_next = 1'b1;
              end
              default: ;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_limit   <= LINE_LIMIT_RESET;
      method_token <= '0;
      method_count <= '0;
      method_kind  <= KIND_UNKNOWN;
      name_length  <= '0;
      line_length  <= '0;
      colon        <= 1'b0;
      cut          <= 1'b0;
      too_long     <= 1'b0;
      skip_next    <= 1'b0;
      dot_seen     <= 1'b0;
      ext_len      <= '0;
      ext_token    <= '0;
      use_default  <= 1'b0;
      bank         <= 1'b0;
      busy         <= '0;
    end else begin
      line_limit   <= line_limit_next;
      method_token <= method_token_next;
      method_count <= method_count_next;
      method_kind  <= method_kind_next;
      name_length  <= name_length_next;
      line_length  <= line_length_next;
      colon        <= colon_next;
      cut          <= cut_next;
      too_long     <= too_long_next;
      skip_next    <= skip_next_next;
      dot_seen     <= dot_seen_next;
      ext_len      <= ext_len_next;
      ext_token    <= ext_token_next;
      use_default  <= use_default_next;
      bank         <= bank_next;
      busy         <= busy_next;
    end
  end

endmodule

// ===== src/hrp_job_q.sv =====
module hrp_job_q
  import hrp_pkg::*;
#(
  parameter int LEN_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  job_t             wr_job,
  input  logic [LEN_W-1:0] wr_len,
  input  logic             rd_en,
  output job_t             rd_job,
  output logic [LEN_W-1:0] rd_len,
  output logic             q_full,
  output logic             q_empty
);

  localparam int PW = $clog2(JOBQ_DEPTH);
  localparam int CW = $clog2(JOBQ_DEPTH + 1);

  job_t             jobs [JOBQ_DEPTH];
  logic [LEN_W-1:0] lens [JOBQ_DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign q_full  = (count == CW'(JOBQ_DEPTH));
  assign q_empty = (count == '0);
  assign rd_job  = jobs[rd_ptr];
  assign rd_len  = lens[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      jobs[wr_ptr] <= wr_job;
      lens[wr_ptr] <= wr_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= (wr_ptr == PW'(JOBQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= (rd_ptr == PW'(JOBQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/hrp_back.sv =====
module hrp_back
  import hrp_pkg::*;
#(
  parameter int NAME_BYTES = 30,
  localparam int LEN_W = $clog2(NAME_BYTES)
) (
  input  logic             clk,
  input  logic             rst,
  input  name_wr_t         wr,
  input  logic [LEN_W-1:0] wr_idx,
  input  job_t             hj,
  input  logic [LEN_W-1:0] hlen,
  input  logic             jq_empty,
  output logic             jq_pop,
  output bank_rel_t        bank_rel,
  output result_t          res,
  output logic             empty,
  input  logic             pop
);

  // two name banks so the front can fill one while the other is emitted
  logic [7:0] name_mem [2][NAME_BYTES];
  logic [7:0] mem_rd;

  logic [LEN_W-1:0] k;
  logic             s1_valid;
  logic             s1_from_mem;
  result_t          s1_res;
  result_t          issue_res;
  result_t          fill_res;

  result_t          outq [OUTQ_DEPTH];
  logic [OQ_PW-1:0] oq_wr, oq_rd;
  logic [OQ_CW-1:0] oq_count;

  logic issue, is_last, space, oq_pop;

  function automatic logic [OQ_PW-1:0] oq_inc(input logic [OQ_PW-1:0] p);
    return (p == OQ_PW'(OUTQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // room is counted with the transaction still in the read stage
  assign space   = ({1'b0, oq_count} + {{OQ_CW{1'b0}}, s1_valid}) < (OQ_CW + 1)'(OUTQ_DEPTH);
  assign issue   = !jq_empty && space;
  assign is_last = !hj.is_name || (k == hlen - 1'b1);
  assign jq_pop  = issue && is_last;
  assign bank_rel.en   = jq_pop && hj.is_name;
  assign bank_rel.bank = hj.bank;

  always_comb begin
    issue_res.verdict    = hj.verdict;
    issue_res.ctype      = hj.is_name ? hj.ctype : CT_HTML;
    issue_res.name_char  = (hj.is_name && hj.use_default) ? default_char(k[3:0]) : 8'h00;
    issue_res.char_valid = hj.is_name;
    issue_res.last       = is_last;
    fill_res             = s1_res;
    if (s1_from_mem) fill_res.name_char = mem_rd;
  end

  always_ff @(posedge clk) begin
    if (wr.en) name_mem[wr.bank][wr_idx] <= wr.data;
    if (issue) mem_rd <= name_mem[hj.bank][k];
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_res      <= issue_res;
      s1_from_mem <= hj.is_name && !hj.use_default;
    end
    if (s1_valid) outq[oq_wr] <= fill_res;
  end

  assign empty  = (oq_count == '0);
  assign res    = outq[oq_rd];
  assign oq_pop = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      k        <= '0;
      s1_valid <= 1'b0;
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      if (jq_pop) k <= '0;
      else if (issue) k <= k + 1'b1;
      s1_valid <= issue;
      if (s1_valid) oq_wr <= oq_inc(oq_wr);
      if (oq_pop) oq_rd <= oq_inc(oq_rd);
      case ({s1_valid, oq_pop})
        2'b10:   oq_count <= oq_count + 1'b1;
        2'b01:   oq_count <= oq_count - 1'b1;
        default: oq_count <= oq_count;
      endcase
    end
  end

endmodule

// ===== src/http_request_header_parser_unit.sv =====
// channel   direction  handshake            payload
// request   in         push / full          data_byte, stream_end
// result    out        pop / empty          verdict, content_type, name_char, char_valid, last
// config    in         cfg_valid / cfg_ready  cfg_data (line limit)
//
// one request byte is taken every cycle while full is low; the parser state is updated per byte
// a queued job passes through the read stage into the output queue, one result per
// cycle while there is room; name bytes are read from a two-bank name store, one read port
// the input stalls only while the job queue is full, or while a path would be
// written into a name bank whose emission has not finished
// rst is synchronous and clears all control state; line limit returns to 5840
module http_request_header_parser_unit
  import hrp_pkg::*;
#(
  parameter int NAME_BYTES = 30
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte,
  input  logic        stream_end,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  verdict,
  output logic [2:0]  content_type,
  output logic [7:0]  name_char,
  output logic        char_valid,
  output logic        last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int LEN_W = $clog2(NAME_BYTES);

  logic             job_push, jq_full, jq_empty, jq_pop;
  job_t             job, hj;
  logic [LEN_W-1:0] job_len, hlen, wr_idx;
  name_wr_t         wr;
  bank_rel_t        bank_rel;
  result_t          res;

  assign cfg_ready = 1'b1;

  hrp_front #(.NAME_BYTES(NAME_BYTES)) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .push       (push),
    .data_byte  (data_byte),
    .stream_end (stream_end),
    .full       (full),
    .jq_full    (jq_full),
    .job_push   (job_push),
    .job        (job),
    .job_len    (job_len),
    .wr         (wr),
    .wr_idx     (wr_idx),
    .bank_rel   (bank_rel)
  );

  hrp_job_q #(.LEN_W(LEN_W)) u_job_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (job),
    .wr_len  (job_len),
    .rd_en   (jq_pop),
    .rd_job  (hj),
    .rd_len  (hlen),
    .q_full  (jq_full),
    .q_empty (jq_empty)
  );

  hrp_back #(.NAME_BYTES(NAME_BYTES)) u_back (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .wr_idx   (wr_idx),
    .hj       (hj),
    .hlen     (hlen),
    .jq_empty (jq_empty),
    .jq_pop   (jq_pop),
    .bank_rel (bank_rel),
    .res      (res),
    .empty    (empty),
    .pop      (pop)
  );

  assign verdict      = res.verdict;
  assign content_type = res.ctype;
  assign name_char    = res.name_char;
  assign char_valid   = res.char_valid;
  assign last         = res.last;

  a_push_room: assert property (@(posedge clk) disable iff (rst) job_push |-> !jq_full)
    else $error("job queued while job queue full");

  a_pop_held: assert property (@(posedge clk) disable iff (rst) jq_pop |-> !jq_empty)
    else $error("job retired from empty queue");

  a_rel_on_pop: assert property (@(posedge clk) disable iff (rst) bank_rel.en |-> jq_pop)
    else $error("name bank released without retiring its job");

  a_wr_on_accept: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> (push && !full && !stream_end))
    else $error("name store written without an accepted byte");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
  import hrp_pkg::*;

  localparam int NAME_BYTES   = 30;
  localparam int DRAIN_CYCLES = 5000;
  localparam int TAIL_CYCLES  = 16;
  localparam logic [7:0] CH_LF = 8'h0A;

  logic        clk;
  logic        rst;
  logic        push;
  logic        full;
  logic [7:0]  data_byte;
  logic        stream_end;
  logic        empty;
  logic        pop;
  logic [2:0]  verdict;
  logic [2:0]  content_type;
  logic [7:0]  name_char;
  logic        char_valid;
  logic        last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  http_request_header_parser_unit #(
    .NAME_BYTES(NAME_BYTES)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .stream_end(stream_end),
    .empty(empty),
    .pop(pop),
    .verdict(verdict),
    .content_type(content_type),
    .name_char(name_char),
    .char_valid(char_valid),
    .last(last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  typedef struct {
    string    text;
    bit       typed;
    verdict_t want;
  } dir_row_t;

  // each row is followed by stream end; typed rows carry their single error verdict
  dir_row_t dir_rows [25] = '{
    '{"", 1'b1, V_ABORT},
    '{"GET /index.png HTTP/1.0\015\012\015\012", 1'b0, V_OK},
    '{"GET / HTTP/1.0\015\012Host: a\015\012\015\012", 1'b0, V_OK},
    '{"GET /a.jpg?x=1.gif HTTP/1.0\015\012\015\012", 1'b0, V_OK},
    '{"GET /b.jpeg H\015\012\015\012", 1'b0, V_OK},
    '{"GET /c.gif H\015\012\015\012", 1'b0, V_OK},
    '{"GET /d.ico H\015\012\015\012", 1'b0, V_OK},
    '{"GET /e.htm H\015\012\015\012", 1'b0, V_OK},
    '{"GET /f.txt H\015\012\015\012", 1'b0, V_OK},
    '{"GET /noext H\015\012\015\012", 1'b0, V_OK},
    '{"GET /g.jpegx H\015\012\015\012", 1'b0, V_OK},
    '{"GET /?only=query H\015\012\015\012", 1'b0, V_OK},
    '{"GET /abcdefghijklmnopqrstuvwx.jpeg H\015\012\015\012", 1'b0, V_OK},
    '{"GET /abcdefghijklmnopqrstuvwxyzABCD H\015\012", 1'b1, V_URI_TOO_LONG},
    '{"POST /form H\015\012A: b\015\012\015\012", 1'b1, V_NOT_ALLOWED},
    '{"PUT /x H\015\012", 1'b1, V_NOT_ALLOWED},
    '{"GETS /x H\015\012", 1'b1, V_NOT_ALLOWED},
    '{" /x H\015\012", 1'b1, V_NOT_ALLOWED},
    '{"GET\015\012", 1'b1, V_ABORT},
    '{"GET \015\012", 1'b1, V_ABORT},
    '{"GET /abc\015\012", 1'b1, V_ABORT},
    '{"GET /a H\015\012NoColon\015\012", 1'b1, V_BAD_REQUEST},
    '{"GET /a H\015\012A: b", 1'b1, V_TOO_LARGE},
    '{"GET /z.ico H\015\012\015\012junk after", 1'b0, V_OK},
    '{"\015\012", 1'b1, V_ABORT}
  };

  string ext_pool [10] = '{".htm", ".html", ".jpg", ".jpeg", ".png", ".gif", ".ico", ".txt",
                           ".jpegs", ".gi"};
  string index_page = "index.html";

  // parser state mirror
  logic [15:0] cur_limit;
  phase_t      ps_phase;
  logic [39:0] ps_token;
  int          ps_count;
  kind_t       ps_kind;
  logic [7:0]  ps_name [NAME_BYTES];
  int          ps_len;
  logic [15:0] ps_line;
  bit          ps_colon, ps_cut, ps_long, ps_skip;

  result_t     new_words [$];
  result_t     pending_results [$];
  logic [7:0]  req_bytes [$];
  logic [15:0] limit_plan [6];

  bit       row_typed, row_pending;
  verdict_t row_verdict;
  int       burst_left;
  int       n_fail, n_inputs, n_counted, n_requests, n_results;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic result_t failure_word(input verdict_t v);
    return '{v, CT_HTML, 8'h00, 1'b0, 1'b1};
  endfunction

  function automatic void rearm_parser();
    ps_phase = PH_METHOD;
    ps_token = '0;
    ps_count = 0;
    ps_kind  = KIND_UNKNOWN;
    ps_len   = 0;
    ps_line  = '0;
    ps_colon = 1'b0;
    ps_cut   = 1'b0;
    ps_long  = 1'b0;
    ps_skip  = 1'b0;
  endfunction

  function automatic void give_verdict(input verdict_t v);
    new_words.push_back(failure_word(v));
    ps_phase = PH_DONE;
  endfunction

  // content type from the first dot of the stored name
  function automatic ctype_t name_type();
    int dot;
    logic [39:0] tok;
    dot = -1;
    for (int i = 0; i < ps_len; i++) if (dot < 0 && ps_name[i] == CH_DOT) dot = i;
    if (dot < 0 || ps_len - dot > 5) return CT_UNKNOWN;
    tok = '0;
    for (int i = dot; i < ps_len; i++) tok = {tok[31:0], ps_name[i]};
    // a four byte tail leaves the top byte clear, so the two widths cannot alias
    case (tok)
      EXT_HTM, EXT_HTML: return CT_HTML;
      EXT_JPG, EXT_JPEG: return CT_JPEG;
      EXT_PNG:           return CT_PNG;
      EXT_GIF:           return CT_GIF;
      EXT_ICO:           return CT_ICON;
      default:           return CT_UNKNOWN;
    endcase
  endfunction

  function automatic void line_done(input bit was_empty);
    ctype_t  ct;
    result_t w;
    case (ps_phase)
      PH_REST: begin
        if (ps_kind == KIND_UNKNOWN) give_verdict(V_NOT_ALLOWED);
        else if (ps_kind == KIND_GET && ps_long) give_verdict(V_URI_TOO_LONG);
        else begin
          ps_colon = 1'b0;
          ps_cut   = 1'b0;
          ps_long  = 1'b0;
          ps_phase = PH_HEADER;
        end
      end
      PH_HEADER: begin
        if (was_empty && ps_kind == KIND_GET) begin
          ct = name_type();
          for (int k = 0; k < ps_len; k++) begin
            w = '{V_OK, ct, ps_name[k], 1'b1, k == ps_len - 1};
            new_words.push_back(w);
          end
          ps_phase = PH_DONE;
        end else if (was_empty) begin
          give_verdict(V_NOT_ALLOWED);
        end else if (!ps_colon) begin
          give_verdict(V_BAD_REQUEST);
        end else begin
          ps_colon = 1'b0;
        end
      end
      default: give_verdict(V_ABORT);
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b, input logic fin);
    if (fin) begin
      if (ps_phase == PH_HEADER) give_verdict(V_TOO_LARGE);
      else if (ps_phase != PH_DONE) give_verdict(V_ABORT);
      rearm_parser();
    end else if (ps_phase != PH_DONE) begin
      if (ps_skip) begin
        ps_skip = 1'b0;
      end else if (b == CH_CR) begin
        ps_skip = 1'b1;
        line_done(ps_line == 0);
        ps_line = '0;
      end else begin
        if (ps_line != 16'hFFFF) ps_line++;
        if (ps_line >= cur_limit) begin
          give_verdict(ps_phase == PH_HEADER ? V_TOO_LARGE : V_ABORT);
        end else begin
          case (ps_phase)
            PH_METHOD: begin
              if (b == CH_SPACE) begin
                if (ps_count == 3 && ps_token == {8'h00, TOK_GET}) begin
                  ps_kind  = KIND_GET;
                  ps_phase = PH_SKIP;
                end else begin
                  ps_kind  = (ps_count == 4 && ps_token == {8'h00, TOK_POST}) ?
                             KIND_POST : KIND_UNKNOWN;
                  ps_phase = PH_REST;
                end
              end else begin
                ps_token = {ps_token[31:0], b};
                if (ps_count < 6) ps_count++;
              end
            end
            PH_SKIP: ps_phase = PH_PATH;
            PH_PATH: begin
              if (b == CH_SPACE) begin
                if (ps_len == 0 && !ps_long) begin
                  for (int i = 0; i < index_page.len(); i++) ps_name[i] = index_page[i];
                  ps_len = index_page.len();
                end
                ps_phase = PH_REST;
              end else if (b == CH_QMARK) begin
                ps_cut = 1'b1;
              end else if (!ps_cut) begin
                if (ps_len < NAME_BYTES - 1) begin
                  ps_name[ps_len] = b;
                  ps_len++;
                end else begin
                  ps_long = 1'b1;
                end
              end
            end
            PH_HEADER: if (b == CH_COLON) ps_colon = 1'b1;
            default: ;
          endcase
        end
      end
    end
  endfunction

  // request transaction with burst pacing; expectations are queued on acceptance
  task automatic send_item(input logic [7:0] b, input logic fin);
    result_t word;
    int      idle;
    if (burst_left == 0) begin
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90) : $urandom_range(1, 12);
      if (idle > 0) begin
        @(negedge clk);
        push <= 1'b0;
        repeat (idle - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    push       <= 1'b1;
    data_byte  <= b;
    stream_end <= fin;
    @(posedge clk);
    while (full) @(posedge clk);
    n_inputs++;
    if (fin || ps_phase != PH_DONE) n_counted++;
    parse_byte(b, fin);
    while (new_words.size() != 0) begin
      word = new_words.pop_front();
      if (!row_typed) begin
        pending_results.push_back(word);
      end else if (row_pending) begin
        pending_results.push_back(failure_word(row_verdict));
        row_pending = 1'b0;
      end
    end
  endtask

  task automatic play_request();
    foreach (req_bytes[i]) send_item(req_bytes[i], 1'b0);
    send_item(8'($urandom_range(0, 255)), 1'b1);
    n_requests++;
  endtask

  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    push <= 1'b0;
    while (pending_results.size() != 0 && waited < DRAIN_CYCLES) begin
      @(posedge clk);
      waited++;
    end
    if (pending_results.size() != 0) begin
      $error("%0d expected results never arrived", pending_results.size());
      n_fail++;
      pending_results.delete();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic set_line_limit(input logic [15:0] v);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cur_limit = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void put_str(input string s);
    for (int i = 0; i < s.len(); i++) req_bytes.push_back(s[i]);
  endfunction

  // mostly printable text, now and then any byte but a carriage return
  function automatic void put_text(input int n);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        do c = 8'($urandom_range(0, 255)); while (c == CH_CR);
      end else begin
        c = 8'($urandom_range(8'h21, 8'h7E));
      end
      req_bytes.push_back(c);
    end
  endfunction

  function automatic void put_eol();
    req_bytes.push_back(CH_CR);
    req_bytes.push_back(($urandom_range(0, 7) != 0) ? CH_LF : 8'($urandom_range(0, 255)));
  endfunction

  function automatic void make_request();
    int pick;
    int keep;
    req_bytes.delete();
    pick = $urandom_range(0, 19);
    if (pick >= 17) begin
      // plain noise, carriage returns included
      repeat ($urandom_range(1, 30))
        req_bytes.push_back(($urandom_range(0, 5) == 0) ? CH_CR : 8'($urandom_range(0, 255)));
    end else begin
      if (pick < 13) put_str("GET ");
      else if (pick < 15) put_str("POST ");
      else begin
        put_text($urandom_range(0, 5));
        req_bytes.push_back(CH_SPACE);
      end
      req_bytes.push_back(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : 8'h2F);
      put_text(($urandom_range(0, 7) == 0) ? $urandom_range(20, 34) : $urandom_range(0, 6));
      if ($urandom_range(0, 3) != 0) put_str(ext_pool[$urandom_range(0, 9)]);
      if ($urandom_range(0, 4) == 0) begin
        req_bytes.push_back(CH_QMARK);
        put_text($urandom_range(0, 6));
      end
      req_bytes.push_back(CH_SPACE);
      put_text($urandom_range(0, 8));
      put_eol();
      repeat ($urandom_range(0, 2)) begin
        put_text($urandom_range(1, 5));
        if ($urandom_range(0, 7) != 0) req_bytes.push_back(CH_COLON);
        put_text($urandom_range(0, 8));
        put_eol();
      end
      put_eol();
      if ($urandom_range(0, 3) == 0) put_text($urandom_range(1, 6));
    end
    // cut the stream short now and then
    if ($urandom_range(0, 7) == 0) begin
      keep = $urandom_range(0, req_bytes.size());
      while (req_bytes.size() > keep) req_bytes.delete(req_bytes.size() - 1);
    end
  endfunction

  // result side: the pop pattern is picked at random among always, half the time and one time in five
  initial begin : result_pacing
    int mode;
    int left;
    pop  = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 2);
        left = $urandom_range(8, 60);
      end
      left--;
      case (mode)
        0:       pop <= 1'b1;
        1:       pop <= ($urandom_range(0, 1) == 1);
        default: pop <= ($urandom_range(0, 9) < 2);
      endcase
    end
  end

  function automatic void check_field(input string field, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", field, want, got);
      n_fail++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (!rst && pop && !empty) begin
      n_results++;
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected: verdict %0d name_char %0h",
               verdict, name_char);
        n_fail++;
      end else begin
        want = pending_results.pop_front();
        check_field("verdict", 8'(want.verdict), 8'(verdict));
        check_field("content_type", 8'(want.ctype), 8'(content_type));
        check_field("name_char", want.name_char, name_char);
        check_field("char_valid", 8'(want.char_valid), 8'(char_valid));
        check_field("last", 8'(want.last), 8'(last));
      end
    end
  end

  initial begin
    int goal;
    rst        = 1'b1;
    push       = 1'b0;
    data_byte  = 8'h00;
    stream_end = 1'b0;
    cfg_valid  = 1'b0;
    cfg_data   = 16'h0000;
    burst_left = 0;
    n_fail     = 0;
    n_inputs   = 0;
    n_counted  = 0;
    n_requests = 0;
    n_results  = 0;
    row_typed  = 1'b0;
    row_pending = 1'b0;
    row_verdict = V_OK;
    cur_limit  = LINE_LIMIT_RESET;
    rearm_parser();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      row_typed   = dir_rows[i].typed;
      row_pending = dir_rows[i].typed;
      row_verdict = dir_rows[i].want;
      for (int k = 0; k < dir_rows[i].text.len(); k++) send_item(dir_rows[i].text[k], 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1);
      n_requests++;
      if (row_pending) begin
        pending_results.push_back(failure_word(row_verdict));
        row_pending = 1'b0;
      end
    end
    row_typed = 1'b0;

    limit_plan = '{16'd1, 16'hFFFF, 16'd24, 16'd48, 16'd0, LINE_LIMIT_RESET};
    limit_plan[4] = 16'($urandom_range(2, 120));
    foreach (limit_plan[i]) begin
      settle();
      set_line_limit(limit_plan[i]);
      goal = n_counted + ((limit_plan[i] == 16'd1) ? 4 : 20);
      while (n_counted < goal) begin
        make_request();
        play_request();
      end
    end
    settle();

    $display("checked %0d result transactions from %0d requests, %0d input transactions",
             n_results, n_requests, n_inputs);
    $display("line limits: reset value, 1, 65535, 24, 48, %0d, then reset value again",
             limit_plan[4]);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #25_000_000;
    $display("run did not finish in time");
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== http_request_header_parser_unit.f =====
src/hrp_pkg.sv
src/hrp_front.sv
src/hrp_job_q.sv
src/hrp_back.sv
src/http_request_header_parser_unit.sv
dv/tb_top.sv
